// File: rtl/poc_pkg.sv
// Shared types and constants for the permutation order crossover block.
// No dependencies; imported by the front end, queue, back end and top level.
`timescale 1ns / 1ps

package poc_pkg;

    localparam int CITY_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int MAX_CITIES  = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] CITY_COUNT_RESET = COUNT_W'(64);

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_FIRST  = 2'd1;
    localparam logic [1:0] CMD_SECOND = 2'd2;

    typedef enum logic [1:0] {
        OP_START,
        OP_FIRST,
        OP_SECOND
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [CITY_W-1:0] city;
        logic [CITY_W-1:0] cut;
    } queue_entry_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_push_t;

endpackage

// File: rtl/poc_front.sv
// Front end: takes input requests, decodes the command and drops unused codes.
// Depends on poc_pkg; feeds poc_queue.
`timescale 1ns / 1ps

module poc_front
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 queue_full,
    output poc_pkg::queue_push_t push
);
    import poc_pkg::*;

    logic accept;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        push.entry.city = s_tdata[CITY_W-1:0];
        push.entry.cut  = s_tdata[2*CITY_W-1:CITY_W];
        push.entry.kind = OP_START;
        push.valid      = 1'b0;
        unique case (s_tuser)
            CMD_START:
            begin
                push.entry.kind = OP_START;
                push.valid      = accept;
            end
            CMD_FIRST:
            begin
                push.entry.kind = OP_FIRST;
                push.valid      = accept;
            end
            CMD_SECOND:
            begin
                push.entry.kind = OP_SECOND;
                push.valid      = accept;
            end
            default:
            begin
                // unused code: consumed, never queued
                push.valid = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/poc_queue.sv
// Short FIFO between the front end and the back end.
// Depends on poc_pkg.
`timescale 1ns / 1ps

module poc_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  poc_pkg::queue_push_t  push,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output poc_pkg::queue_entry_t head
);
    import poc_pkg::*;

    queue_entry_t      mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// File: rtl/poc_back.sv
// Back end: seen bitmap, counters and the output register.
// Depends on poc_pkg; pops entries from poc_queue.
`timescale 1ns / 1ps

module poc_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [poc_pkg::COUNT_W-1:0]  city_count,
    input  logic                         queue_empty,
    input  poc_pkg::queue_entry_t        head,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,
    output logic                         m_tlast
);
    import poc_pkg::*;

    logic [(1<<CITY_W)-1:0] seen_reg, seen_next;
    logic [COUNT_W-1:0]     prefix_reg, prefix_next;
    logic [COUNT_W-1:0]     emitted_reg, emitted_next;
    logic [CITY_W-1:0]      cut_reg, cut_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CITY_W-1:0]      out_city_reg;
    logic                   out_last_reg;

    logic [COUNT_W-1:0]     limit;
    logic [COUNT_W-1:0]     emitted_inc;
    logic                   room;
    logic                   emit;
    logic                   advance;

    assign advance     = !out_valid_reg || m_tready;
    assign pop         = !queue_empty && advance;
    assign limit       = (city_count > COUNT_W'(MAX_CITIES)) ? COUNT_W'(MAX_CITIES) : city_count;
    assign room        = emitted_reg < limit;
    assign emitted_inc = emitted_reg + 1'b1;

    always_comb
    begin
        seen_next    = seen_reg;
        prefix_next  = prefix_reg;
        emitted_next = emitted_reg;
        cut_next     = cut_reg;
        emit         = 1'b0;
        if (pop)
        begin
            unique case (head.kind)
                OP_START:
                begin
                    seen_next    = '0;
                    prefix_next  = '0;
                    emitted_next = '0;
                    cut_next     = head.cut;
                end
                OP_FIRST:
                begin
                    emit = (prefix_reg < {1'b0, cut_reg}) && room;
                    if (prefix_reg != '1)
                    begin
                        prefix_next = prefix_reg + 1'b1;
                    end
                end
                OP_SECOND:
                begin
                    emit = !seen_reg[head.city] && room;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
            if (emit)
            begin
                seen_next[head.city] = 1'b1;
                emitted_next         = emitted_inc;
            end
        end
        out_valid_next = advance ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            prefix_reg    <= '0;
            emitted_reg   <= '0;
            cut_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            prefix_reg    <= prefix_next;
            emitted_reg   <= emitted_next;
            cut_reg       <= cut_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_city_reg <= head.city;
            out_last_reg <= (emitted_inc == limit);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8-CITY_W){1'b0}}, out_city_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/permutation_order_crossover_core.sv
// Top level of the one-point order crossover block: front end, queue, back end.
// Depends on poc_pkg, poc_front, poc_queue and poc_back.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------
//   s_*      | in        | tuser = cmd; tdata = city[5:0], cut_point[11:6]
//   m_*      | out       | tdata = child_city[5:0]; tlast = is_last
//   cfg_*    | in        | cfg_data = city_count[6:0]
//
// One request per clock unless output stalls; requests are queued, results registered.
// The back end tests and sets seen-bitmap bits, one element per cycle unless stalled.
// A four-entry queue decouples input and output; s_tready drops only when it is full.
// Output stalls back up through the queue; unused command codes are dropped at entry.
// rst_n clears the bitmap, counters and queue at once; city_count returns to 64.
`timescale 1ns / 1ps

module permutation_order_crossover_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] city, [11:6] cut_point, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] child_city, [7:6] zero
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // [6:0] city_count
);
    import poc_pkg::*;

    logic [COUNT_W-1:0] city_count_reg, city_count_next;
    queue_push_t        push;
    queue_entry_t       head;
    logic               queue_full;
    logic               queue_empty;
    logic               pop;

    assign cfg_ready       = 1'b1;
    assign city_count_next = (cfg_valid && cfg_ready) ? cfg_data : city_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            city_count_reg <= CITY_COUNT_RESET;
        end
        else
        begin
            city_count_reg <= city_count_next;
        end
    end

    poc_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push)
    );

    poc_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .pop   (pop),
        .empty (queue_empty),
        .head  (head)
    );

    poc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .city_count  (city_count_reg),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// File: rtl/poc_checker.sv
// Port-level checks for the crossover block, bound to the top level.
// Depends on permutation_order_crossover_core ports only.
`timescale 1ns / 1ps

module poc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       cfg_ready
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_out_pad: assert property (@(posedge clk)
        m_tvalid |-> m_tdata[7:6] == 2'b00)
        else $error("city above range on output");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result shown during reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config write stalled");

endmodule

bind permutation_order_crossover_core poc_checker u_poc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);

// File: bench/poc_crossover_checker.sv
// Scoreboard for permutation_order_crossover_core: watches the request, result and
// config channels, predicts each child city and compares. Depends on poc_pkg.
`timescale 1ns / 1ps

module poc_crossover_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] city, [11:6] cut_point, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [5:0] child_city, [7:6] zero
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [6:0]  cfg_data,  // [6:0] city_count
    output int          fail_count,
    output int          pending
);
    import poc_pkg::*;

    typedef struct packed {
        logic [CITY_W-1:0] city;
        logic              last;
    } child_item_t;

    child_item_t child_expected[$];

    logic [MAX_CITIES-1:0] seen_map;
    logic [COUNT_W-1:0]    prefix_pos;
    logic [COUNT_W-1:0]    emitted;
    logic [CITY_W-1:0]     cut_len;
    logic [COUNT_W-1:0]    city_count;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // counts above the table size behave as a full table
    function automatic logic [COUNT_W-1:0] emit_limit(input logic [COUNT_W-1:0] n);
        return (n > COUNT_W'(MAX_CITIES)) ? COUNT_W'(MAX_CITIES) : n;
    endfunction

    task automatic emit_child(input logic [CITY_W-1:0] c);
        child_item_t item;
        seen_map[c] = 1'b1;
        emitted     = emitted + 1'b1;
        item.city   = c;
        item.last   = (emitted == emit_limit(city_count));
        child_expected.insert(child_expected.size(), item);
    endtask

    task automatic predict_crossover(input logic [1:0] cmd, input logic [CITY_W-1:0] c,
                                     input logic [CITY_W-1:0] cut);
        logic room;
        logic take;
        room = emitted < emit_limit(city_count);
        case (cmd)
            CMD_START:
            begin
                seen_map   = '0;
                prefix_pos = '0;
                emitted    = '0;
                cut_len    = cut;
            end
            CMD_FIRST:
            begin
                take = prefix_pos < COUNT_W'(cut_len);
                if (prefix_pos != '1)
                    prefix_pos = prefix_pos + 1'b1;
                // prefix cities pass straight through, seen or not
                if (take && room)
                    emit_child(c);
            end
            CMD_SECOND:
            begin
                if (!seen_map[c] && room)
                    emit_child(c);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        child_item_t want;
        if (!rst_n)
        begin
            seen_map   = '0;
            prefix_pos = '0;
            emitted    = '0;
            cut_len    = '0;
            city_count = CITY_COUNT_RESET;
            child_expected.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                city_count = cfg_data;
            // results trail their requests, so retire before predicting this edge's request
            if (m_tvalid && m_tready)
            begin
                if (child_expected.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected child_city %0d last %0b", $time,
                             m_tdata[CITY_W-1:0], m_tlast);
                end
                else
                begin
                    want = child_expected.pop_front();
                    if (m_tdata[CITY_W-1:0] != want.city)
                    begin
                        fail_count++;
                        $display("%0t: child_city expected %0d, got %0d", $time,
                                 want.city, m_tdata[CITY_W-1:0]);
                    end
                    if (m_tlast != want.last)
                    begin
                        fail_count++;
                        $display("%0t: is_last expected %0b, got %0b", $time,
                                 want.last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_crossover(s_tuser, s_tdata[CITY_W-1:0], s_tdata[2*CITY_W-1:CITY_W]);
            pending = child_expected.size();
        end
    end

endmodule

// File: bench/permutation_order_crossover_core_test.sv
// Top of the crossover bench: clock, reset, request and config stimulus, output stalls.
// Depends on poc_pkg, permutation_order_crossover_core and poc_crossover_checker.
`timescale 1ns / 1ps

module permutation_order_crossover_core_test;
    import poc_pkg::*;

    localparam logic [1:0] CMD_SPARE     = 2'd3;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         ITEM_TARGET   = 640;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    int fail_count;
    int pending;
    int idle_cycles;
    int items_sent;
    int gap_max;
    int stall_max;

    int count_plan[20] = '{2, 3, 5, 8, 4, 64, 16, 0, 6, 1, 33, 127, 3, 12, 100, 7, 2,
                           64, 10, 5};

    logic [CITY_W-1:0] city_pool[MAX_CITIES];
    logic [CITY_W-1:0] parent_a[$];
    logic [CITY_W-1:0] parent_b[$];

    permutation_order_crossover_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    poc_crossover_checker watch
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("permutation_order_crossover_core_test: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: random stall before each result
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [CITY_W-1:0] city,
                                input logic [CITY_W-1:0] cut);
        int gap;
        gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, cut, city};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd != CMD_SPARE)
            items_sent++;
    endtask

    // hold off requests until every expected child city is out and the pipe is quiet
    task automatic drain_and_settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_city_count(input logic [6:0] value);
        drain_and_settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // n distinct cities out of the full range, second parent a reordering of the first
    task automatic draw_parents(input int n);
        int j;
        logic [CITY_W-1:0] t;
        for (int i = 0; i < MAX_CITIES; i++)
            city_pool[i] = CITY_W'(i);
        for (int i = MAX_CITIES - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = city_pool[i];
            city_pool[i] = city_pool[j];
            city_pool[j] = t;
        end
        parent_a.delete();
        parent_b.delete();
        for (int i = 0; i < n; i++)
        begin
            parent_a.insert(parent_a.size(), city_pool[i]);
            parent_b.insert(parent_b.size(), city_pool[i]);
        end
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = parent_b[i];
            parent_b[i] = parent_b[j];
            parent_b[j] = t;
        end
    endtask

    task automatic run_crossover(input int count);
        int lim;
        int n;
        int style;
        int ia;
        int ib;
        logic [CITY_W-1:0] cut;
        lim   = (count > MAX_CITIES) ? MAX_CITIES : count;
        n     = (lim < 2) ? $urandom_range(2, 6) : lim;
        style = $urandom_range(0, 9);
        if ($urandom_range(0, 7) == 0 || n >= 63)
            cut = CITY_W'($urandom_range(0, 63));
        else
            cut = CITY_W'($urandom_range(0, n));
        draw_parents(n);
        if (style >= 8)
        begin
            // noise, including unused commands and elements with no start
            repeat ($urandom_range(1, 20))
                send_request(2'($urandom_range(0, 3)), CITY_W'($urandom_range(0, 63)),
                             CITY_W'($urandom_range(0, 63)));
            return;
        end
        send_request(CMD_START, CITY_W'($urandom_range(0, 63)), cut);
        if (style < 6)
        begin
            foreach (parent_a[i])
                send_request(CMD_FIRST, parent_a[i], CITY_W'($urandom_range(0, 63)));
            foreach (parent_b[i])
                send_request(CMD_SECOND, parent_b[i], CITY_W'($urandom_range(0, 63)));
        end
        else
        begin
            // parents interleaved, first-parent elements may trail
            ia = 0;
            ib = 0;
            while (ia < n || ib < n)
            begin
                if (ib >= n || (ia < n && $urandom_range(0, 1) == 1))
                begin
                    send_request(CMD_FIRST, parent_a[ia], CITY_W'($urandom_range(0, 63)));
                    ia++;
                end
                else
                begin
                    send_request(CMD_SECOND, parent_b[ib], CITY_W'($urandom_range(0, 63)));
                    ib++;
                end
            end
        end
    endtask

    initial
    begin
        int phase;
        int count;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_START;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        idle_cycles = 0;
        items_sent = 0;
        gap_max    = 15;
        stall_max  = 15;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;

        // elements before any start run on the reset state with a zero cut
        send_request(CMD_FIRST, 6'd21, 6'd0);
        send_request(CMD_SECOND, 6'd0, 6'd0);
        send_request(CMD_SECOND, 6'd63, 6'd63);
        send_request(CMD_SPARE, 6'd63, 6'd63);
        send_request(CMD_START, 6'd63, 6'd63);
        send_request(CMD_FIRST, 6'd63, 6'd0);
        send_request(CMD_FIRST, 6'd63, 6'd0);
        send_request(CMD_SECOND, 6'd63, 6'd0);
        send_request(CMD_SECOND, 6'd42, 6'd0);
        send_request(CMD_FIRST, 6'd10, 6'd0);
        send_request(CMD_START, 6'd0, 6'd0);
        send_request(CMD_FIRST, 6'd5, 6'd0);
        send_request(CMD_SECOND, 6'd5, 6'd0);
        write_city_count(7'd0);
        send_request(CMD_START, 6'd0, 6'd2);
        send_request(CMD_FIRST, 6'd1, 6'd0);
        send_request(CMD_SECOND, 6'd2, 6'd0);
        write_city_count(7'd1);
        send_request(CMD_START, 6'd0, 6'd1);
        send_request(CMD_FIRST, 6'd42, 6'd0);
        send_request(CMD_SECOND, 6'd7, 6'd0);
        send_request(CMD_FIRST, 6'd9, 6'd0);
        write_city_count(7'd2);
        send_request(CMD_START, 6'd0, 6'd1);
        send_request(CMD_FIRST, 6'd3, 6'd0);
        send_request(CMD_SECOND, 6'd3, 6'd0);
        send_request(CMD_SECOND, 6'd60, 6'd0);
        send_request(CMD_SECOND, 6'd61, 6'd0);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase < 20)
                count = count_plan[phase];
            else
                count = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 64) :
                        $urandom_range(2, 10);
            case (phase % 4)
                0:
                begin
                    gap_max   = 15;
                    stall_max = 15;
                end
                1:
                begin
                    gap_max   = 0;
                    stall_max = 0;
                end
                2:
                begin
                    gap_max   = 0;
                    stall_max = 15;
                end
                default:
                begin
                    gap_max   = 15;
                    stall_max = 0;
                end
            endcase
            write_city_count(7'(count));
            repeat ((count >= 33) ? 1 : 3)
                run_crossover(count);
            phase++;
        end

        // prefix position runs past its saturation point
        gap_max   = 0;
        stall_max = 0;
        write_city_count(7'd64);
        send_request(CMD_START, 6'd0, 6'd63);
        repeat (130)
            send_request(CMD_FIRST, CITY_W'($urandom_range(0, 63)), 6'd0);

        drain_and_settle();
        if (fail_count == 0)
            $display("permutation_order_crossover_core_test: PASS");
        else
            $display("permutation_order_crossover_core_test: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/poc_pkg.sv
rtl/poc_front.sv
rtl/poc_queue.sv
rtl/poc_back.sv
rtl/permutation_order_crossover_core.sv
rtl/poc_checker.sv
bench/poc_crossover_checker.sv
bench/permutation_order_crossover_core_test.sv
